[src/vna_pkg.sv]
package vna_pkg;

	localparam int INDEX_BITS = 10;
	localparam int POS_BITS = 16;
	localparam int NORMAL_BITS = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_STEPS = 16;
	localparam int SQRT_STEPS = 32;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_FACE  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                         cmd;
		logic [INDEX_BITS-1:0]        vertex_index;
		logic signed [POS_BITS-1:0]   pos_x;
		logic signed [POS_BITS-1:0]   pos_y;
		logic signed [POS_BITS-1:0]   pos_z;
		logic [INDEX_BITS-1:0]        corner_a;
		logic [INDEX_BITS-1:0]        corner_b;
		logic [INDEX_BITS-1:0]        corner_c;
	} request_t;

	typedef struct packed {
		logic signed [NORMAL_BITS-1:0] normal_x;
		logic signed [NORMAL_BITS-1:0] normal_y;
		logic signed [NORMAL_BITS-1:0] normal_z;
		logic                          zero_length;
		logic [INDEX_BITS-1:0]         read_index;
	} result_t;

	typedef struct packed {
		request_t req;
		logic     idx_ok;
	} queue_entry_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_SWEEP,
		BK_VRD,
		BK_MUL,
		BK_SRD,
		BK_SWR,
		BK_NRD,
		BK_NGO,
		BK_NWAIT
	} back_state_t;

	typedef enum logic [2:0] {
		NM_IDLE,
		NM_SHIFT,
		NM_SQ,
		NM_SQRT,
		NM_DSET,
		NM_DIV,
		NM_OUT
	} norm_state_t;

endpackage

[src/vertex_normal_accumulator.sv]
// Channel   Ports                          Handshake
// request   start, busy, request           taken when start is high and busy is low
// result    result_valid, result           one-cycle strobe, cannot be held off
//
// A vertex write is stored as the back end pops it; a face does three vertex reads,
// six products on one multiplier and three sum read-modify-writes.
// A read goes through the one-bit-per-cycle scaling shift, the 32-step square root and
// three 16-step divides in the normalizer; a zero sum skips them and returns its result
// straight from the scaling state.
// A clear, and the pass after reset, sweep all VERTEX_COUNT touched flags;
// busy is high for the whole pass after reset and whenever the two-entry queue is full.
module vertex_normal_accumulator #(
	parameter int VERTEX_COUNT = 1024,
	parameter int COORD_BITS = 16,
	parameter int SUM_BITS = 44
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  vna_pkg::request_t request,
	output logic              result_valid,
	output vna_pkg::result_t  result
);

	logic                           init_busy;
	logic                           q_valid;
	vna_pkg::queue_entry_t          q_entry;
	logic                           q_pop;
	logic                           norm_go;
	logic [vna_pkg::INDEX_BITS-1:0] norm_index;
	logic signed [SUM_BITS-1:0]     norm_sx;
	logic signed [SUM_BITS-1:0]     norm_sy;
	logic signed [SUM_BITS-1:0]     norm_sz;

	vna_front #(.VERTEX_COUNT(VERTEX_COUNT)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.request   (request),
		.init_busy (init_busy),
		.busy      (busy),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop)
	);

	vna_back #(
		.VERTEX_COUNT (VERTEX_COUNT),
		.COORD_BITS   (COORD_BITS),
		.SUM_BITS     (SUM_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_entry    (q_entry),
		.q_pop      (q_pop),
		.init_busy  (init_busy),
		.norm_go    (norm_go),
		.norm_index (norm_index),
		.norm_sx    (norm_sx),
		.norm_sy    (norm_sy),
		.norm_sz    (norm_sz),
		.norm_done  (result_valid)
	);

	vna_norm #(.SUM_BITS(SUM_BITS)) u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (norm_go),
		.index  (norm_index),
		.sx     (norm_sx),
		.sy     (norm_sy),
		.sz     (norm_sz),
		.result (result),
		.valid  (result_valid)
	);

endmodule

[src/vna_ram.sv]
module vna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/vna_front.sv]
module vna_front #(
	parameter int VERTEX_COUNT = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  vna_pkg::request_t     request,
	input  logic                  init_busy,
	output logic                  busy,
	output logic                  q_valid,
	output vna_pkg::queue_entry_t q_entry,
	input  logic                  q_pop
);

	localparam int PW = $clog2(vna_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(vna_pkg::QUEUE_DEPTH + 1);

	vna_pkg::queue_entry_t fifo_q [vna_pkg::QUEUE_DEPTH];
	logic [PW-1:0]         wr_q;
	logic [PW-1:0]         rd_q;
	logic [CW-1:0]         cnt_q;
	logic                  idx_ok;
	logic                  face_ok;
	logic                  keep;
	logic                  push;
	logic                  pop;

	always_comb begin
		idx_ok  = 32'(request.vertex_index) < VERTEX_COUNT;
		face_ok = (32'(request.corner_a) < VERTEX_COUNT) &&
			(32'(request.corner_b) < VERTEX_COUNT) &&
			(32'(request.corner_c) < VERTEX_COUNT);
		unique case (request.cmd)
			vna_pkg::CMD_WRITE: keep = idx_ok;
			vna_pkg::CMD_FACE:  keep = face_ok;
			default:            keep = 1'b1;
		endcase
	end

	assign busy    = (cnt_q == CW'(vna_pkg::QUEUE_DEPTH)) || init_busy;
	assign push    = start && !busy && keep;
	assign q_valid = cnt_q != '0;
	assign pop     = q_pop && q_valid;
	assign q_entry = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(vna_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(vna_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q].req    <= request;
			fifo_q[wr_q].idx_ok <= idx_ok;
		end
	end

endmodule

[src/vna_norm.sv]
module vna_norm #(
	parameter int SUM_BITS = 44
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                go,
	input  logic [vna_pkg::INDEX_BITS-1:0]      index,
	input  logic signed [SUM_BITS-1:0]          sx,
	input  logic signed [SUM_BITS-1:0]          sy,
	input  logic signed [SUM_BITS-1:0]          sz,
	output vna_pkg::result_t                    result,
	output logic                                valid
);

	localparam int MW = SUM_BITS;

	vna_pkg::norm_state_t st_q;
	vna_pkg::norm_state_t st_d;
	logic [MW-1:0]        mag_q [3];
	logic [2:0]           neg_q;
	logic [vna_pkg::INDEX_BITS-1:0] idx_q;
	logic [4:0]           cnt_q;
	logic [1:0]           k_q;
	logic [59:0]          sq_q;
	logic [61:0]          acc_q;
	logic [62:0]          n_q;
	logic [62:0]          r_q;
	logic [62:0]          bit_q;
	logic [47:0]          rem_q;
	logic [47:0]          ds_q;
	logic [15:0]          quo_q;
	logic [15:0]          qres_q [3];
	vna_pkg::result_t     res_q;
	logic                 valid_q;
	logic [MW-1:0]        orv;
	logic [29:0]          sq_op;
	logic [29:0]          div_op;
	logic [63:0]          trial;
	logic [15:0]          quo_d;

	assign orv = mag_q[0] | mag_q[1] | mag_q[2];
	assign trial = {1'b0, r_q} + {1'b0, bit_q};
	assign quo_d = {quo_q[14:0], rem_q >= ds_q};

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    sq_op = mag_q[0][29:0];
			2'd1:    sq_op = mag_q[1][29:0];
			default: sq_op = mag_q[2][29:0];
		endcase
		unique case (k_q)
			2'd0:    div_op = mag_q[0][29:0];
			2'd1:    div_op = mag_q[1][29:0];
			default: div_op = mag_q[2][29:0];
		endcase
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			vna_pkg::NM_IDLE: begin
				if (go) begin
					st_d = vna_pkg::NM_SHIFT;
				end
			end
			vna_pkg::NM_SHIFT: begin
				if (orv == '0) begin
					st_d = vna_pkg::NM_IDLE;
				end else if (orv[MW-1:30] == '0 && orv[29]) begin
					st_d = vna_pkg::NM_SQ;
				end
			end
			vna_pkg::NM_SQ: begin
				if (cnt_q == 5'd3) begin
					st_d = vna_pkg::NM_SQRT;
				end
			end
			vna_pkg::NM_SQRT: begin
				if (cnt_q == 5'(vna_pkg::SQRT_STEPS - 1)) begin
					st_d = vna_pkg::NM_DSET;
				end
			end
			vna_pkg::NM_DSET: begin
				st_d = vna_pkg::NM_DIV;
			end
			vna_pkg::NM_DIV: begin
				if (cnt_q == 5'(vna_pkg::DIV_STEPS - 1)) begin
					st_d = (k_q == 2'd2) ? vna_pkg::NM_OUT : vna_pkg::NM_DSET;
				end
			end
			vna_pkg::NM_OUT: begin
				st_d = vna_pkg::NM_IDLE;
			end
			default: st_d = vna_pkg::NM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= vna_pkg::NM_IDLE;
			valid_q <= 1'b0;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			st_q    <= st_d;
			valid_q <= (st_q == vna_pkg::NM_OUT) ||
				(st_q == vna_pkg::NM_SHIFT && orv == '0);
			cnt_q   <= (st_d != st_q) ? 5'd0 : cnt_q + 1'b1;
			if (st_q == vna_pkg::NM_SQRT) begin
				k_q <= '0;
			end else if (st_q == vna_pkg::NM_DIV && st_d == vna_pkg::NM_DSET) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			vna_pkg::NM_IDLE: begin
				idx_q    <= index;
				neg_q    <= {sz[MW-1], sy[MW-1], sx[MW-1]};
				mag_q[0] <= sx[MW-1] ? $unsigned(-sx) : $unsigned(sx);
				mag_q[1] <= sy[MW-1] ? $unsigned(-sy) : $unsigned(sy);
				mag_q[2] <= sz[MW-1] ? $unsigned(-sz) : $unsigned(sz);
			end
			vna_pkg::NM_SHIFT: begin
				if (orv == '0) begin
					res_q.normal_x    <= '0;
					res_q.normal_y    <= '0;
					res_q.normal_z    <= '0;
					res_q.zero_length <= 1'b1;
					res_q.read_index  <= idx_q;
				end else if (orv[MW-1:30] != '0) begin
					for (int k = 0; k < 3; k++) begin
						mag_q[k] <= mag_q[k] >> 1;
					end
				end else if (!orv[29]) begin
					for (int k = 0; k < 3; k++) begin
						mag_q[k] <= mag_q[k] << 1;
					end
				end
				acc_q <= '0;
			end
			vna_pkg::NM_SQ: begin
				sq_q <= sq_op * sq_op;
				if (cnt_q == 5'd1 || cnt_q == 5'd2) begin
					acc_q <= acc_q + 62'(sq_q);
				end
				if (cnt_q == 5'd3) begin
					n_q   <= 63'(acc_q) + 63'(sq_q);
					r_q   <= '0;
					bit_q <= 63'(1) << 62;
				end
			end
			vna_pkg::NM_SQRT: begin
				if ({1'b0, n_q} >= trial) begin
					n_q <= n_q - trial[62:0];
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			vna_pkg::NM_DSET: begin
				rem_q <= {3'b0, div_op, 15'b0} + 48'(r_q[31:0]);
				ds_q  <= {r_q[31:0], 16'b0};
				quo_q <= '0;
			end
			vna_pkg::NM_DIV: begin
				if (rem_q >= ds_q) begin
					rem_q <= rem_q - ds_q;
				end
				ds_q  <= ds_q >> 1;
				quo_q <= quo_d;
				if (cnt_q == 5'(vna_pkg::DIV_STEPS - 1)) begin
					qres_q[k_q] <= quo_d;
				end
			end
			vna_pkg::NM_OUT: begin
				res_q.normal_x    <= neg_q[0] ? 16'd0 - qres_q[0] : qres_q[0];
				res_q.normal_y    <= neg_q[1] ? 16'd0 - qres_q[1] : qres_q[1];
				res_q.normal_z    <= neg_q[2] ? 16'd0 - qres_q[2] : qres_q[2];
				res_q.zero_length <= 1'b0;
				res_q.read_index  <= idx_q;
			end
			default: begin
			end
		endcase
	end

	assign result = res_q;
	assign valid  = valid_q;

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |=> !valid_q)
		else $error("result strobe held for more than one cycle");

	a_zero_normal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.zero_length |->
		res_q.normal_x == '0 && res_q.normal_y == '0 && res_q.normal_z == '0)
		else $error("zero-length result carries a nonzero normal");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> res_q.normal_x >= -16'sd16384 && res_q.normal_x <= 16'sd16384 &&
		res_q.normal_y >= -16'sd16384 && res_q.normal_y <= 16'sd16384 &&
		res_q.normal_z >= -16'sd16384 && res_q.normal_z <= 16'sd16384)
		else $error("normal component outside the unit range");

endmodule

[src/vna_back.sv]
module vna_back #(
	parameter int VERTEX_COUNT = 1024,
	parameter int COORD_BITS = 16,
	parameter int SUM_BITS = 44
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	input  vna_pkg::queue_entry_t            q_entry,
	output logic                             q_pop,
	output logic                             init_busy,
	output logic                             norm_go,
	output logic [vna_pkg::INDEX_BITS-1:0]   norm_index,
	output logic signed [SUM_BITS-1:0]       norm_sx,
	output logic signed [SUM_BITS-1:0]       norm_sy,
	output logic signed [SUM_BITS-1:0]       norm_sz,
	input  logic                             norm_done
);

	localparam int AW = $clog2(VERTEX_COUNT);
	localparam int CB = COORD_BITS;
	localparam int VW = 3 * CB;
	localparam int EW = CB + 1;
	localparam int PW = 2 * EW;
	localparam int CRW = PW + 1;
	localparam int XW = ((CRW > SUM_BITS) ? CRW : SUM_BITS) + 1;
	localparam int SW3 = 3 * SUM_BITS;

	vna_pkg::back_state_t state_q;
	vna_pkg::back_state_t state_d;
	logic                 init_q;
	logic [AW-1:0]        sweep_q;
	logic [2:0]           step_q;
	logic [1:0]           corner_q;
	vna_pkg::queue_entry_t cur_q;
	logic signed [CB-1:0]  va_q [3];
	logic signed [EW-1:0]  e1_q [3];
	logic signed [EW-1:0]  e2_q [3];
	logic signed [PW-1:0]  prod_q;
	logic signed [PW-1:0]  hold_q;
	logic signed [CRW-1:0] cr_q [3];
	logic signed [EW-1:0]  mul_a;
	logic signed [EW-1:0]  mul_b;
	logic signed [PW-1:0]  prod_d;
	logic                  sweep_last;

	logic            v_we;
	logic [AW-1:0]   v_waddr;
	logic [VW-1:0]   v_wdata;
	logic [AW-1:0]   v_raddr;
	logic [VW-1:0]   v_rdata;
	logic            s_we;
	logic [AW-1:0]   s_waddr;
	logic [SW3-1:0]  s_wdata;
	logic [AW-1:0]   s_raddr;
	logic [SW3-1:0]  s_rdata;
	logic            t_we;
	logic [AW-1:0]   t_waddr;
	logic [0:0]      t_wdata;
	logic [0:0]      t_rdata;
	logic [AW-1:0]   corner_addr;
	logic [SW3-1:0]  sum_new;
	logic [VW-1:0]   pos_word;

	function automatic logic [CB-1:0] to_coord(input logic [vna_pkg::POS_BITS-1:0] p);
		logic [31:0] wide;
		wide = {16'b0, p};
		return wide[CB-1:0];
	endfunction

	function automatic logic [SUM_BITS-1:0] sat_add(input logic signed [SUM_BITS-1:0] s,
		input logic signed [CRW-1:0] c);
		logic signed [XW-1:0] t;
		t = XW'(s) + XW'(c);
		if (t[XW-1:SUM_BITS-1] == '0 || t[XW-1:SUM_BITS-1] == '1) begin
			return t[SUM_BITS-1:0];
		end
		return t[XW-1] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
	endfunction

	vna_ram #(.WIDTH(VW), .DEPTH(VERTEX_COUNT)) u_vertex_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	vna_ram #(.WIDTH(SW3), .DEPTH(VERTEX_COUNT)) u_sum_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	vna_ram #(.WIDTH(1), .DEPTH(VERTEX_COUNT)) u_touched_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (s_raddr),
		.rdata (t_rdata)
	);

	assign sweep_last = sweep_q == AW'(VERTEX_COUNT - 1);
	assign init_busy  = init_q;
	assign pos_word   = {to_coord(q_entry.req.pos_z), to_coord(q_entry.req.pos_y),
		to_coord(q_entry.req.pos_x)};

	always_comb begin
		unique case (corner_q)
			2'd0:    corner_addr = AW'(cur_q.req.corner_a);
			2'd1:    corner_addr = AW'(cur_q.req.corner_b);
			default: corner_addr = AW'(cur_q.req.corner_c);
		endcase
	end

	always_comb begin
		logic signed [SUM_BITS-1:0] base;
		sum_new = '0;
		for (int k = 0; k < 3; k++) begin
			base = t_rdata[0] ? signed'(s_rdata[k*SUM_BITS +: SUM_BITS]) : '0;
			sum_new[k*SUM_BITS +: SUM_BITS] = sat_add(base, cr_q[k]);
		end
	end

	always_comb begin
		unique case (step_q)
			3'd0:    begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
			3'd1:    begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
			3'd2:    begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
			3'd3:    begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
			3'd4:    begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
			3'd5:    begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		prod_d = mul_a * mul_b;
	end

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		norm_go    = 1'b0;
		v_we       = 1'b0;
		v_waddr    = AW'(q_entry.req.vertex_index);
		v_wdata    = pos_word;
		v_raddr    = AW'(cur_q.req.corner_a);
		s_we       = 1'b0;
		s_waddr    = corner_addr;
		s_wdata    = sum_new;
		s_raddr    = corner_addr;
		t_we       = 1'b0;
		t_waddr    = corner_addr;
		t_wdata    = 1'b1;
		norm_index = cur_q.req.vertex_index;
		norm_sx    = '0;
		norm_sy    = '0;
		norm_sz    = '0;
		unique case (state_q)
			vna_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_entry.req.cmd)
						vna_pkg::CMD_CLEAR: state_d = vna_pkg::BK_SWEEP;
						vna_pkg::CMD_WRITE: v_we = 1'b1;
						vna_pkg::CMD_FACE:  state_d = vna_pkg::BK_VRD;
						vna_pkg::CMD_READ:  state_d = vna_pkg::BK_NRD;
					endcase
				end
			end
			vna_pkg::BK_SWEEP: begin
				t_we    = 1'b1;
				t_waddr = sweep_q;
				t_wdata = 1'b0;
				if (sweep_last) begin
					state_d = vna_pkg::BK_IDLE;
				end
			end
			vna_pkg::BK_VRD: begin
				unique case (step_q)
					3'd0:    v_raddr = AW'(cur_q.req.corner_a);
					3'd1:    v_raddr = AW'(cur_q.req.corner_b);
					default: v_raddr = AW'(cur_q.req.corner_c);
				endcase
				if (step_q == 3'd3) begin
					state_d = vna_pkg::BK_MUL;
				end
			end
			vna_pkg::BK_MUL: begin
				if (step_q == 3'd6) begin
					state_d = vna_pkg::BK_SRD;
				end
			end
			vna_pkg::BK_SRD: begin
				state_d = vna_pkg::BK_SWR;
			end
			vna_pkg::BK_SWR: begin
				s_we = 1'b1;
				t_we = 1'b1;
				state_d = (corner_q == 2'd2) ? vna_pkg::BK_IDLE : vna_pkg::BK_SRD;
			end
			vna_pkg::BK_NRD: begin
				s_raddr = AW'(cur_q.req.vertex_index);
				state_d = vna_pkg::BK_NGO;
			end
			vna_pkg::BK_NGO: begin
				norm_go = 1'b1;
				if (cur_q.idx_ok && t_rdata[0]) begin
					norm_sx = s_rdata[0 +: SUM_BITS];
					norm_sy = s_rdata[SUM_BITS +: SUM_BITS];
					norm_sz = s_rdata[2*SUM_BITS +: SUM_BITS];
				end
				state_d = vna_pkg::BK_NWAIT;
			end
			vna_pkg::BK_NWAIT: begin
				if (norm_done) begin
					state_d = vna_pkg::BK_IDLE;
				end
			end
			default: state_d = vna_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= vna_pkg::BK_SWEEP;
			init_q   <= 1'b1;
			sweep_q  <= '0;
			step_q   <= '0;
			corner_q <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_d != state_q) ? 3'd0 : step_q + 1'b1;
			if (state_q == vna_pkg::BK_SWEEP) begin
				sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
				if (sweep_last) begin
					init_q <= 1'b0;
				end
			end
			if (state_q == vna_pkg::BK_IDLE) begin
				corner_q <= '0;
			end else if (state_q == vna_pkg::BK_SWR) begin
				corner_q <= corner_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_entry;
		end
		if (state_q == vna_pkg::BK_VRD) begin
			for (int k = 0; k < 3; k++) begin
				if (step_q == 3'd1) begin
					va_q[k] <= signed'(v_rdata[k*CB +: CB]);
				end
				if (step_q == 3'd2) begin
					e1_q[k] <= EW'(signed'(v_rdata[k*CB +: CB])) - EW'(va_q[k]);
				end
				if (step_q == 3'd3) begin
					e2_q[k] <= EW'(signed'(v_rdata[k*CB +: CB])) - EW'(va_q[k]);
				end
			end
		end
		if (state_q == vna_pkg::BK_MUL) begin
			prod_q <= prod_d;
			unique case (step_q)
				3'd1, 3'd3, 3'd5: hold_q <= prod_q;
				3'd2:             cr_q[0] <= CRW'(hold_q) - CRW'(prod_q);
				3'd4:             cr_q[1] <= CRW'(hold_q) - CRW'(prod_q);
				3'd6:             cr_q[2] <= CRW'(hold_q) - CRW'(prod_q);
				default: begin
				end
			endcase
		end
	end

endmodule

[tb/sv/vertex_normal_accumulator_tb.sv]
module vertex_normal_accumulator_tb;

	localparam int NVERT = 1024;
	localparam int SUMW = 44;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	vna_pkg::request_t request = '0;
	logic result_valid;
	vna_pkg::result_t result;

	vertex_normal_accumulator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .result_valid(result_valid), .result(result)
	);

	always #4 clk = ~clk;

	logic signed [15:0] pos_mem [NVERT][3];
	logic signed [SUMW-1:0] acc_mem [NVERT][3];
	bit touched_mem [NVERT];
	bit written [NVERT];
	int written_list [$];
	vna_pkg::result_t normal_queue [$];
	int errors = 0;
	int normals_seen = 0;
	int items_sent = 0;
	bit gaps_on = 1'b1;
	longint cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("vertex_normal_accumulator_tb failed");
			$finish;
		end
	end

	function automatic logic signed [SUMW-1:0] sat_sum(logic signed [SUMW-1:0] s,
			longint c);
		longint hi, lo, r;
		hi = (longint'(1) <<< (SUMW - 1)) - 1;
		lo = -hi - 1;
		r = longint'(s) + c;
		if (r > hi) r = hi;
		if (r < lo) r = lo;
		return r[SUMW-1:0];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic vna_pkg::result_t unit_normal(logic [9:0] idx);
		vna_pkg::result_t r;
		longint s [3];
		longint unsigned mag [3];
		longint unsigned m, len, q;
		bit neg [3];
		r = '0;
		r.read_index = idx;
		m = 0;
		for (int k = 0; k < 3; k++) begin
			s[k] = touched_mem[idx] ? longint'(acc_mem[idx][k]) : 0;
			neg[k] = s[k] < 0;
			mag[k] = neg[k] ? -s[k] : s[k];
			if (mag[k] > m) m = mag[k];
		end
		if (m == 0) begin
			r.zero_length = 1'b1;
			return r;
		end
		while (m >= (64'd1 << 30)) begin
			m >>= 1;
			for (int k = 0; k < 3; k++) mag[k] >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			m <<= 1;
			for (int k = 0; k < 3; k++) mag[k] <<= 1;
		end
		len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
		for (int k = 0; k < 3; k++) begin
			q = (mag[k] * 32768 + len) / (2 * len);
			if (neg[k]) q = -q;
			if (k == 0) r.normal_x = q[15:0];
			else if (k == 1) r.normal_y = q[15:0];
			else r.normal_z = q[15:0];
		end
		return r;
	endfunction

	function automatic void apply_request(vna_pkg::request_t rq);
		longint e1 [3], e2 [3], cr [3];
		int corner [3];
		case (rq.cmd)
			vna_pkg::CMD_CLEAR: foreach (touched_mem[i]) touched_mem[i] = 1'b0;
			vna_pkg::CMD_WRITE: begin
				pos_mem[rq.vertex_index][0] = rq.pos_x;
				pos_mem[rq.vertex_index][1] = rq.pos_y;
				pos_mem[rq.vertex_index][2] = rq.pos_z;
				if (!written[rq.vertex_index])
					written_list = {written_list, int'(rq.vertex_index)};
				written[rq.vertex_index] = 1'b1;
			end
			vna_pkg::CMD_FACE: begin
				corner[0] = int'(rq.corner_a);
				corner[1] = int'(rq.corner_b);
				corner[2] = int'(rq.corner_c);
				for (int k = 0; k < 3; k++) begin
					e1[k] = longint'(pos_mem[corner[1]][k]) - longint'(pos_mem[corner[0]][k]);
					e2[k] = longint'(pos_mem[corner[2]][k]) - longint'(pos_mem[corner[0]][k]);
				end
				cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
				cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
				cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
				for (int v = 0; v < 3; v++) begin
					if (!touched_mem[corner[v]]) begin
						for (int k = 0; k < 3; k++) acc_mem[corner[v]][k] = '0;
						touched_mem[corner[v]] = 1'b1;
					end
					for (int k = 0; k < 3; k++)
						acc_mem[corner[v]][k] = sat_sum(acc_mem[corner[v]][k], cr[k]);
				end
			end
			vna_pkg::CMD_READ:
				normal_queue = {normal_queue, unit_normal(rq.vertex_index)};
		endcase
	endfunction

	always @(posedge clk) begin
		vna_pkg::result_t want;
		if (arst_n && result_valid) begin
			normals_seen++;
			if (normal_queue.size() == 0) begin
				$error("unexpected result for vertex %0d", result.read_index);
				errors++;
			end else begin
				want = normal_queue.pop_front();
				if (result.normal_x !== want.normal_x) begin
					$error("normal_x expected %0d got %0d", want.normal_x, result.normal_x);
					errors++;
				end
				if (result.normal_y !== want.normal_y) begin
					$error("normal_y expected %0d got %0d", want.normal_y, result.normal_y);
					errors++;
				end
				if (result.normal_z !== want.normal_z) begin
					$error("normal_z expected %0d got %0d", want.normal_z, result.normal_z);
					errors++;
				end
				if (result.zero_length !== want.zero_length) begin
					$error("zero_length expected %0d got %0d", want.zero_length,
						result.zero_length);
					errors++;
				end
				if (result.read_index !== want.read_index) begin
					$error("read_index expected %0d got %0d", want.read_index,
						result.read_index);
					errors++;
				end
			end
		end
	end

	task automatic send_request(vna_pkg::request_t rq);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			gap = $urandom_range(1, 7);
			repeat (gap) @(negedge clk);
		end
		request <= rq;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		apply_request(rq);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic vna_pkg::request_t noise_fill();
		vna_pkg::request_t rq;
		rq.cmd = vna_pkg::CMD_CLEAR;
		rq.vertex_index = 10'($urandom);
		rq.pos_x = 16'($urandom);
		rq.pos_y = 16'($urandom);
		rq.pos_z = 16'($urandom);
		rq.corner_a = 10'($urandom);
		rq.corner_b = 10'($urandom);
		rq.corner_c = 10'($urandom);
		return rq;
	endfunction

	task automatic write_vertex(int idx, int x, int y, int z);
		vna_pkg::request_t rq;
		rq = noise_fill();
		rq.cmd = vna_pkg::CMD_WRITE;
		rq.vertex_index = 10'(idx);
		rq.pos_x = 16'(x);
		rq.pos_y = 16'(y);
		rq.pos_z = 16'(z);
		send_request(rq);
	endtask

	task automatic add_face(int a, int b, int c);
		vna_pkg::request_t rq;
		rq = noise_fill();
		rq.cmd = vna_pkg::CMD_FACE;
		rq.corner_a = 10'(a);
		rq.corner_b = 10'(b);
		rq.corner_c = 10'(c);
		send_request(rq);
	endtask

	task automatic read_normal(int idx);
		vna_pkg::request_t rq;
		rq = noise_fill();
		rq.cmd = vna_pkg::CMD_READ;
		rq.vertex_index = 10'(idx);
		send_request(rq);
	endtask

	task automatic clear_sums();
		send_request(noise_fill());
	endtask

	function automatic int pick_written();
		return written_list[$urandom_range(0, written_list.size() - 1)];
	endfunction

	task automatic test_extremes();
		read_normal(0);
		read_normal(1023);
		write_vertex(0, -32768, -32768, -32768);
		write_vertex(1, 32767, -32768, 32767);
		write_vertex(2, -32768, 32767, 32767);
		write_vertex(1023, 0, 0, 0);
		write_vertex(3, 0, 0, 0);
		add_face(0, 1, 2);
		read_normal(0);
		for (int i = 0; i < 8; i++) add_face(0, 1, 2);
		read_normal(1);
		read_normal(3);
		add_face(3, 3, 3);
		read_normal(3);
		add_face(1023, 1023, 0);
		read_normal(1023);
		clear_sums();
		read_normal(0);
		add_face(2, 1, 0);
		read_normal(2);
	endtask

	task automatic test_saturation();
		for (int i = 0; i < 40; i++) add_face(0, 1, 2);
		read_normal(0);
		add_face(0, 2, 1);
		read_normal(0);
	endtask

	task automatic test_random_mesh(int count);
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 25 || written_list.size() < 3)
				write_vertex((r < 5) ? $urandom_range(0, 1023) : $urandom_range(0, 63),
					$urandom, $urandom, (r < 15) ? $urandom_range(0, 255) : $urandom);
			else if (r < 62)
				add_face(pick_written(), pick_written(), pick_written());
			else if (r < 97)
				read_normal(r < 92 ? pick_written() : $urandom_range(0, 1023));
			else
				clear_sums();
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_saturation();
		test_random_mesh(1400);
		gaps_on = 1'b0;
		test_random_mesh(300);
		start <= 1'b0;
		while (normal_queue.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Sent %0d requests with random mesh edits, faces, clears and reads;",
			items_sent);
		$display("checked %0d normals including large and zero sums.", normals_seen);
		if (errors == 0 && normal_queue.size() == 0)
			$display("vertex_normal_accumulator_tb passed");
		else
			$display("vertex_normal_accumulator_tb failed");
		$finish;
	end

endmodule

[filelist.f]
src/vna_pkg.sv
src/vna_ram.sv
src/vna_front.sv
src/vna_norm.sv
src/vna_back.sv
src/vertex_normal_accumulator.sv
tb/sv/vertex_normal_accumulator_tb.sv
